### design/cmre_pkg.sv
// cmre_pkg: shared types and constants of the cigar match region extractor
// word structs for both channels, character codes, operator classes, queue sizing
// no dependencies
package cmre_pkg;

	localparam int POS_WIDTH_DEF = 32;
	localparam int LEN_WIDTH     = 32;
	localparam int OUT_WIDTH     = 32;

	// result queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;

	// ascii codes
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_M  = 8'h4D;
	localparam logic [7:0] CH_D  = 8'h44;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_X  = 8'h58;
	localparam logic [7:0] CH_I  = 8'h49;
	localparam logic [7:0] CH_S  = 8'h53;
	localparam logic [7:0] CH_H  = 8'h48;
	localparam logic [7:0] CH_P  = 8'h50;
	localparam logic [7:0] CH_N  = 8'h4E;

	// operator classes
	localparam logic [2:0] OP_DIGIT   = 3'd0;
	localparam logic [2:0] OP_ADVANCE = 3'd1;
	localparam logic [2:0] OP_CLOSE   = 3'd2;
	localparam logic [2:0] OP_SKIP    = 3'd3;
	localparam logic [2:0] OP_BAD     = 3'd4;

	typedef struct packed {
		logic [7:0]  character;
		logic [31:0] start_pos;
		logic        first_char;
		logic        last_char;
	} in_word_t;

	typedef struct packed {
		logic [31:0] region_start;
		logic [31:0] region_end;
		logic        region_valid;
		logic        end_of_read;
		logic        parse_error;
	} out_word_t;

	function automatic logic [2:0] op_class(input logic [7:0] ch);
		logic [2:0] cls;
		if (ch >= CH_0 && ch <= CH_9) begin
			cls = OP_DIGIT;
		end else begin
			unique case (ch)
				CH_M, CH_D, CH_EQ, CH_X: cls = OP_ADVANCE;
				CH_I, CH_S, CH_H, CH_P:  cls = OP_CLOSE;
				CH_N:                    cls = OP_SKIP;
				default:                 cls = OP_BAD;
			endcase
		end
		return cls;
	endfunction

endpackage

### design/cmre_front.sv
// cmre_front: accepts cigar characters, keeps length and position state,
// and pushes zero, one or two result entries into the queue per word
// depends on cmre_pkg
module cmre_front import cmre_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_word_t                 in_word,
	input  logic                     space_ok,
	output logic [1:0]               push_n,
	output logic [2*POS_WIDTH+2:0]   push_w0,
	output logic [2*POS_WIDTH+2:0]   push_w1
);

	localparam int SUM_W = ((POS_WIDTH > LEN_WIDTH) ? POS_WIDTH : LEN_WIDTH) + 1;
	localparam int MUL_W = LEN_WIDTH + 4;

	logic [LEN_WIDTH-1:0] len_q;
	logic [POS_WIDTH-1:0] bs_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic                 err_q;

	logic                 acc;
	logic [SUM_W-1:0]     sp_x;
	logic                 sp_ovf;
	logic [LEN_WIDTH-1:0] len0;
	logic [POS_WIDTH-1:0] bs0;
	logic [POS_WIDTH-1:0] pos0;
	logic                 err0;
	logic [2:0]           cls;
	logic [MUL_W-1:0]     len_x10;
	logic                 len_ovf;
	logic [SUM_W-1:0]     sum;
	logic                 adv_ovf;
	logic [POS_WIDTH-1:0] sum_pos;
	logic [LEN_WIDTH-1:0] len1;
	logic [POS_WIDTH-1:0] bs1;
	logic [POS_WIDTH-1:0] pos1;
	logic                 err1;
	logic                 r1v;
	logic                 r2v;
	logic [2*POS_WIDTH+2:0] r1;
	logic [2*POS_WIDTH+2:0] r2;

	assign in_stall = !space_ok;
	assign acc      = in_valid && space_ok;

	// reload from the start position on the first character
	assign sp_x   = SUM_W'(in_word.start_pos);
	assign sp_ovf = |sp_x[SUM_W-1:POS_WIDTH];
	assign len0   = in_word.first_char ? '0 : len_q;
	assign err0   = in_word.first_char ? sp_ovf : err_q;
	assign bs0    = in_word.first_char ? (sp_ovf ? '0 : sp_x[POS_WIDTH-1:0]) : bs_q;
	assign pos0   = in_word.first_char ? (sp_ovf ? '0 : sp_x[POS_WIDTH-1:0]) : pos_q;

	assign cls     = op_class(in_word.character);
	// len * 10 + digit
	assign len_x10 = MUL_W'({len0, 3'b000}) + MUL_W'({len0, 1'b0})
		+ MUL_W'(in_word.character[3:0]);
	assign len_ovf = |len_x10[MUL_W-1:LEN_WIDTH];
	assign sum     = SUM_W'(pos0) + SUM_W'(len0);
	assign adv_ovf = |sum[SUM_W-1:POS_WIDTH];
	assign sum_pos = sum[POS_WIDTH-1:0];

	always_comb begin
		len1 = len0;
		bs1  = bs0;
		pos1 = pos0;
		err1 = err0;
		r1v  = 1'b0;
		if (!err0) begin
			unique case (cls)
				OP_DIGIT: begin
					if (len_ovf) begin
						err1 = 1'b1;
					end else begin
						len1 = len_x10[LEN_WIDTH-1:0];
					end
				end
				OP_ADVANCE: begin
					len1 = '0;
					if (adv_ovf) begin
						err1 = 1'b1;
					end else begin
						pos1 = sum_pos;
					end
				end
				OP_CLOSE: begin
					len1 = '0;
					r1v  = (bs0 != pos0);
					bs1  = pos0;
				end
				OP_SKIP: begin
					len1 = '0;
					r1v  = (bs0 != pos0);
					if (adv_ovf) begin
						err1 = 1'b1;
					end else begin
						pos1 = sum_pos;
						bs1  = sum_pos;
					end
				end
				default: begin
					len1 = '0;
					err1 = 1'b1;
				end
			endcase
		end
	end

	// entry layout: valid, end of read, error, start, end
	assign r1  = {1'b1, 1'b0, 1'b0, bs0, pos0 - POS_WIDTH'(1)};
	assign r2v = !err1 && (bs1 != pos1);
	assign r2  = r2v ? {1'b1, 1'b1, 1'b0, bs1, pos1 - POS_WIDTH'(1)}
		: {1'b0, 1'b1, err1, {(2*POS_WIDTH){1'b0}}};

	assign push_n  = acc ? (2'(r1v) + 2'(in_word.last_char)) : 2'd0;
	assign push_w0 = r1v ? r1 : r2;
	assign push_w1 = r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			bs_q  <= '0;
			pos_q <= '0;
			err_q <= 1'b0;
		end else if (acc) begin
			pos_q <= pos1;
			err_q <= err1;
			if (in_word.last_char) begin
				len_q <= '0;
				bs_q  <= r2v ? pos1 : bs1;
			end else begin
				len_q <= len1;
				bs_q  <= bs1;
			end
		end
	end

endmodule

### design/cmre_queue.sv
// cmre_queue: small result queue, up to two writes and one read per cycle
// depends on cmre_pkg
module cmre_queue import cmre_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_n,
	input  logic [2*POS_WIDTH+2:0] push_w0,
	input  logic [2*POS_WIDTH+2:0] push_w1,
	output logic                   space_ok,
	input  logic                   pop,
	output logic                   head_valid,
	output logic [2*POS_WIDTH+2:0] head
);

	logic [2*POS_WIDTH+2:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wp_q;
	logic [PTR_W-1:0]       rp_q;
	logic [CNT_W-1:0]       cnt_q;

	// room for two entries before a word is taken
	assign space_ok   = cnt_q <= CNT_W'(QUEUE_DEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= push_w0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_q + PTR_W'(1)] <= push_w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push_n);
			rp_q  <= rp_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

### design/cmre_back.sv
// cmre_back: drains the result queue into the output register and formats words
// depends on cmre_pkg
module cmre_back import cmre_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  logic [2*POS_WIDTH+2:0] head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_word
);

	logic                          vld_q;
	out_word_t                     word_q;
	logic                          e_valid;
	logic [POS_WIDTH+OUT_WIDTH-1:0] start_x;
	logic [POS_WIDTH+OUT_WIDTH-1:0] end_x;
	out_word_t                     fmt;

	assign pop = head_valid && (!vld_q || !out_stall);

	assign e_valid = head[2*POS_WIDTH+2];
	assign start_x = {{OUT_WIDTH{1'b0}}, head[2*POS_WIDTH-1:POS_WIDTH]};
	assign end_x   = {{OUT_WIDTH{1'b0}}, head[POS_WIDTH-1:0]};

	// low output bits of the positions, zero on an end marker
	always_comb begin
		fmt.region_start = e_valid ? start_x[OUT_WIDTH-1:0] : '0;
		fmt.region_end   = e_valid ? end_x[OUT_WIDTH-1:0] : '0;
		fmt.region_valid = e_valid;
		fmt.end_of_read  = head[2*POS_WIDTH+1];
		fmt.parse_error  = head[2*POS_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= fmt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	assign out_valid = vld_q;
	assign out_word  = word_q;

endmodule

### design/cigar_match_region_extractor_top.sv
// cigar_match_region_extractor_top: one cigar character word in per cycle while in_stall is low;
// each result is written into the queue when its character is taken, then loaded into the output register
// sustains one character per cycle while in_stall is low; a character that closes a region and is also
// the last one makes two results, and the output drains one result per cycle while out_stall is low
// reset clears length, region start, position, error flag and the queue at once
// depends on cmre_pkg, cmre_front, cmre_queue, cmre_back
module cigar_match_region_extractor_top import cmre_pkg::*; #(
	// reference positions are kept in this many bits; the user keeps it within 16 to 64, the block does not enforce it
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	// character channel
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	// region channel
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	// queue entry: valid, end of read, error, start and end positions
	logic [1:0]             push_n;
	logic [2*POS_WIDTH+2:0] push_w0;
	logic [2*POS_WIDTH+2:0] push_w1;
	logic                   space_ok;
	logic                   pop;
	logic                   head_valid;
	logic [2*POS_WIDTH+2:0] head;

	// front: parses digits and operators, updates position state,
	// stalls only when the queue cannot take two more entries
	cmre_front #(
		.POS_WIDTH (POS_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.space_ok (space_ok),
		.push_n   (push_n),
		.push_w0  (push_w0),
		.push_w1  (push_w1)
	);

	// short queue decoupling the front from output stalls
	cmre_queue #(
		.POS_WIDTH (POS_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_w0    (push_w0),
		.push_w1    (push_w1),
		.space_ok   (space_ok),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: output register, loads from the queue whenever an entry waits and it is empty or being taken
	cmre_back #(
		.POS_WIDTH (POS_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

endmodule
